// ----- rtl/core/pcm_mix_pkg.sv -----
`timescale 1ns / 1ps
package pcm_mix_pkg;

	localparam int VoicesDef = 16;
	localparam int SampleAddrBitsDef = 16;
	localparam int FramesW = 17;
	localparam int GainW = 8;
	localparam int CmdW = 3;
	localparam int VoiceFieldW = 4;
	localparam int MaskW = 16;
	localparam int AccW = 24;

	typedef enum logic [CmdW-1:0] {
		CMD_WRITE  = 3'd0,
		CMD_START  = 3'd1,
		CMD_PARAMS = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_t;

	// Command record handed from the front to the back through the queue.
	typedef struct packed {
		logic [CmdW-1:0]        cmd;
		logic [VoiceFieldW-1:0] voice;
		logic                   vok;
		logic [GainW-1:0]       lgain;
		logic [GainW-1:0]       rgain;
		logic [15:0]            address;
		logic [FramesW-1:0]     frames;
		logic [7:0]             raw_byte;
	} pm_cmd_t;

	// Gain = clamp(num * vol / 127) to 0..255, num in -1..255.
	function automatic logic [GainW-1:0] gain_of(input logic signed [9:0] num,
			input logic [6:0] vol);
		logic signed [17:0] p;
		logic [16:0] q;
		logic [16:0] g;
		begin
			p = num * $signed({1'b0, vol});
			if (p <= 0) begin
				gain_of = '0;
			end else begin
				// The reciprocal estimate is low by at most one; one correction fixes it.
				q = 17'((32'(p) * 32'd1032) >> 17);
				g = q;
				if (17'(p) - 17'(q * 17'd127) >= 17'd127) begin
					g = q + 17'd1;
				end
				gain_of = (g > 17'd255) ? 8'd255 : g[7:0];
			end
		end
	endfunction

endpackage

// ----- rtl/core/pcm_mix_front.sv -----
`timescale 1ns / 1ps
module pcm_mix_front import pcm_mix_pkg::*; #(
	parameter int VOICES = VoicesDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CmdW-1:0]        cmd,
	input  logic [VoiceFieldW-1:0] voice,
	input  logic [6:0]             volume,
	input  logic [7:0]             separation,
	input  logic [15:0]            address,
	input  logic [FramesW-1:0]     frame_count,
	input  logic [7:0]             raw_byte,
	output logic                   q_valid,
	input  logic                   q_pop,
	output pm_cmd_t                q_data
);

	localparam int Depth = 2;

	pm_cmd_t     entry_q [Depth];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	pm_cmd_t     cls;
	logic        push;

	// Classify the item and work out both gains up front.
	always_comb begin
		cls.cmd      = cmd;
		cls.voice    = voice;
		cls.vok      = 32'(voice) < VOICES;
		cls.lgain    = gain_of(10'sd254 - $signed({2'b0, separation}), volume);
		cls.rgain    = gain_of($signed({2'b0, separation}), volume);
		cls.address  = address;
		cls.frames   = frame_count;
		cls.raw_byte = raw_byte;
	end

	assign in_stall = (cnt_q == 2'(Depth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = entry_q[rd_ptr_q];

	// Two-entry queue toward the back end.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- rtl/core/pcm_mix_back.sv -----
`timescale 1ns / 1ps
module pcm_mix_back import pcm_mix_pkg::*; #(
	parameter int VOICES = VoicesDef,
	parameter int SAMPLE_ADDR_BITS = SampleAddrBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  pm_cmd_t             q_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  left_out,
	output logic signed [15:0]  right_out,
	output logic [MaskW-1:0]    playing_mask
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = SAMPLE_ADDR_BITS;
	localparam int MemDepth = 1 << AW;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WALK = 5'b00010,
		ST_READ = 5'b00100,
		ST_MULT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                state_q;
	logic [VOICES-1:0]     active_q;
	logic [FramesW-1:0]    pos_q    [VOICES];
	logic [AW-1:0]         start_q  [VOICES];
	logic [FramesW-1:0]    frames_q [VOICES];
	logic [GainW-1:0]      lg_q     [VOICES];
	logic [GainW-1:0]      rg_q     [VOICES];
	logic [7:0]            mem      [MemDepth];
	logic [7:0]            rd_q;
	logic [VW-1:0]         vi_q;
	logic signed [AccW-1:0] lacc_q, racc_q;
	logic signed [31:0]    lprod_q, rprod_q;
	logic                  out_valid_q;
	logic signed [15:0]    left_q, right_q;
	logic [MaskW-1:0]      mask_q;
	logic                  last_voice;
	logic [VW-1:0]         vsel;
	logic signed [15:0]    smp;
	logic signed [AccW-1:0] lq, rq;

	assign vsel       = VW'(q_data.voice);
	assign last_voice = (32'(vi_q) == VOICES - 1);
	assign smp        = $signed({~rd_q[7], rd_q[6:0], 8'h00});
	assign out_valid  = out_valid_q;
	assign left_out   = left_q;
	assign right_out  = right_q;
	assign playing_mask = mask_q;

	// Simple commands leave the queue when applied; a tick leaves when its frame is posted.
	assign q_pop = ((state_q == ST_IDLE) && q_valid && !out_valid_q
		&& (q_data.cmd != CMD_TICK)) || (state_q == ST_DONE);

	// Signed division by 255 toward zero, through the magnitude.
	function automatic logic signed [AccW-1:0] div255(input logic signed [31:0] p);
		logic [31:0] m;
		logic [31:0] q;
		begin
			m = p[31] ? 32'(-p) : 32'(p);
			q = 32'((64'(m) * 64'd32896) >> 23);
			if (m - q * 32'd255 >= 32'd255) begin
				q = q + 32'd1;
			end
			div255 = p[31] ? -$signed(AccW'(q)) : $signed(AccW'(q));
		end
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] x);
		begin
			if (x > 32767) begin
				sat16 = 16'sd32767;
			end else if (x < -32768) begin
				sat16 = -16'sd32768;
			end else begin
				sat16 = x[15:0];
			end
		end
	endfunction

	function automatic logic [MaskW-1:0] mask_of(input logic [VOICES-1:0] a);
		logic [MaskW-1:0] m;
		begin
			m = '0;
			for (int i = 0; i < VOICES && i < MaskW; i++) begin
				m[i] = a[i];
			end
			mask_of = m;
		end
	endfunction

	assign lq = div255(lprod_q);
	assign rq = div255(rprod_q);

	// Sample memory: written by write_byte, read one voice at a time on tick.
	always_ff @(posedge clk) begin
		if (q_pop && q_data.cmd == CMD_WRITE) begin
			mem[AW'(q_data.address)] <= q_data.raw_byte;
		end
		if (state_q == ST_WALK) begin
			rd_q <= mem[start_q[vi_q] + AW'(pos_q[vi_q])];
		end
		if (state_q == ST_READ) begin
			lprod_q <= smp * $signed({1'b0, lg_q[vi_q]});
			rprod_q <= smp * $signed({1'b0, rg_q[vi_q]});
		end
	end

	// Command sequencer: simple commands are applied in the idle state; a tick walks the voices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			vi_q        <= '0;
			lacc_q      <= '0;
			racc_q      <= '0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			mask_q      <= '0;
			for (int i = 0; i < VOICES; i++) begin
				pos_q[i]    <= '0;
				start_q[i]  <= '0;
				frames_q[i] <= '0;
				lg_q[i]     <= '0;
				rg_q[i]     <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && !out_valid_q) begin
						if (q_data.cmd == CMD_TICK) begin
							vi_q    <= '0;
							lacc_q  <= '0;
							racc_q  <= '0;
							state_q <= ST_WALK;
						end else begin
							logic [VOICES-1:0] na;
							na = active_q;
							if (q_data.vok) begin
								if (q_data.cmd == CMD_START && q_data.frames != '0) begin
									na[vsel]       = 1'b1;
									pos_q[vsel]    <= '0;
									start_q[vsel]  <= AW'(q_data.address);
									frames_q[vsel] <= q_data.frames;
									lg_q[vsel]     <= q_data.lgain;
									rg_q[vsel]     <= q_data.rgain;
								end else if (q_data.cmd == CMD_START
										|| q_data.cmd == CMD_STOP) begin
									na[vsel]       = 1'b0;
									pos_q[vsel]    <= '0;
									start_q[vsel]  <= '0;
									frames_q[vsel] <= '0;
									lg_q[vsel]     <= '0;
									rg_q[vsel]     <= '0;
								end else if (q_data.cmd == CMD_PARAMS) begin
									lg_q[vsel] <= q_data.lgain;
									rg_q[vsel] <= q_data.rgain;
								end
							end
							active_q    <= na;
							left_q      <= '0;
							right_q     <= '0;
							mask_q      <= mask_of(na);
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_WALK: begin
					if (!active_q[vi_q]) begin
						if (last_voice) state_q <= ST_DONE;
						else vi_q <= vi_q + 1'b1;
					end else if (pos_q[vi_q] >= frames_q[vi_q]) begin
						active_q[vi_q] <= 1'b0;
						pos_q[vi_q]    <= '0;
						start_q[vi_q]  <= '0;
						frames_q[vi_q] <= '0;
						lg_q[vi_q]     <= '0;
						rg_q[vi_q]     <= '0;
						if (last_voice) state_q <= ST_DONE;
						else vi_q <= vi_q + 1'b1;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					lacc_q      <= lacc_q + lq;
					racc_q      <= racc_q + rq;
					pos_q[vi_q] <= pos_q[vi_q] + 1'b1;
					if (last_voice) begin
						state_q <= ST_DONE;
					end else begin
						vi_q    <= vi_q + 1'b1;
						state_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					left_q      <= sat16(lacc_q);
					right_q     <= sat16(racc_q);
					mask_q      <= mask_of(active_q);
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/multichannel_pcm_mixer.sv -----
`timescale 1ns / 1ps
// Sixteen-voice PCM playback mixer. Each accepted item (write_byte, start, params, stop
// or tick) yields exactly one result holding the mixed stereo frame (zero except on
// tick) and the mask of playing voices after the command. A front end works out the
// pan gains and queues up to two items; the back end applies each one. A tick walks
// the voices one at a time through the single sample-memory read port and one
// multiplier pair: an idle voice is only checked in the walk state, a playing one
// goes through the walk, read and multiply states; the idle state takes the item
// and the done state posts the frame.
// Sample memory is not cleared after reset; only written bytes may be played.
module multichannel_pcm_mixer import pcm_mix_pkg::*; #(
	parameter int VOICES = VoicesDef,
	parameter int SAMPLE_ADDR_BITS = SampleAddrBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CmdW-1:0]        cmd,
	input  logic [VoiceFieldW-1:0] voice,
	input  logic [6:0]             volume,
	input  logic [7:0]             separation,
	input  logic [15:0]            address,
	input  logic [FramesW-1:0]     frame_count,
	input  logic [7:0]             raw_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [15:0]     left_out,
	output logic signed [15:0]     right_out,
	output logic [MaskW-1:0]       playing_mask
);

	logic    q_valid, q_pop;
	pm_cmd_t q_data;

	pcm_mix_front #(.VOICES(VOICES)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .voice, .volume, .separation,
		.address, .frame_count, .raw_byte,
		.q_valid, .q_pop, .q_data
	);

	pcm_mix_back #(.VOICES(VOICES), .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.out_valid, .out_stall, .left_out, .right_out, .playing_mask
	);

endmodule

// ----- rtl/core/pcm_mix_checker.sv -----
`timescale 1ns / 1ps
module pcm_mix_checker import pcm_mix_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [CmdW-1:0]   cmd,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [15:0] left_out,
	input logic signed [15:0] right_out,
	input logic [MaskW-1:0]  playing_mask
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out)
			&& $stable(playing_mask))
		else $error("result changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(cmd))
		else $error("input item changed while stalled");

	a_out_not_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(playing_mask))
		else $error("unknown voice mask");

endmodule

bind multichannel_pcm_mixer pcm_mix_checker u_pcm_mix_checker (
	.clk, .arst_n, .in_valid, .in_stall, .cmd, .out_valid, .out_stall,
	.left_out, .right_out, .playing_mask
);
